// File: hw/rtl/fdc_pkg.sv
`timescale 1ns / 1ps
package fdc_pkg;
   localparam int unsigned MaxN = 1023;
   localparam int unsigned NumW = 10;
   localparam int unsigned ExpW = 10;
   localparam int unsigned ResW = 30;
   localparam int unsigned ModW = 30;
   localparam logic [ModW-1:0] Modulus = 30'd1000000007;
   localparam logic [NumW-1:0] MaxNVal = NumW'(MaxN);

   typedef enum logic [3:0] {
      OP_IDLE, OP_CLEAR, OP_LOADK, OP_DIV, OP_BUMP, OP_NEXTI, OP_LEFTOVER,
      OP_NEXTK, OP_SCAN_RD, OP_SCAN_MUL, OP_MOD, OP_SCAN_NEXT, OP_DONE
   } op_type;

   typedef struct packed {
      logic clear_last;
      logic k_last;
      logic div_done;
      logic divisible;
      logic cand_over;
      logic rest_gt1;
      logic scan_last;
      logic exp_nonzero;
      logic mod_done;
   } status_type;
endpackage

// File: hw/rtl/factorial_divisor_count.sv
`timescale 1ns / 1ps
// Divisor count of n!, mod 1000000007. One transaction in flight at a time.
// Steps: clear of the exponent table, then trial division of every k <= n
// by a bit-serial restoring divider, then a scan of the table with a bit-serial
// modular multiply per nonzero exponent. A new transaction is taken
// only once the last one is done. Result strobes for one cycle;
// the receiver cannot stall. Synchronous reset returns the block to idle.
module factorial_divisor_count (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [fdc_pkg::NumW-1:0]  req_number,
   output logic                      rsp_valid,
   output logic [fdc_pkg::ResW-1:0]  rsp_divisor_count
);
   import fdc_pkg::*;

   op_type     op;
   status_type status;
   logic       div_start, mod_start;
   logic [ResW-1:0] product;

   // control: sequences clear, factorisation and product scan
   fdc_controller u_ctrl (
      .clock, .reset, .start, .status, .op,
      .div_start, .mod_start, .busy, .rsp_valid
   );

   // datapath: exponent memory, divider and modular multiplier
   fdc_datapath u_dp (
      .clock, .op, .div_start, .mod_start, .req_number, .status, .product
   );

   assign rsp_divisor_count = product;
endmodule

// File: hw/rtl/fdc_datapath.sv
`timescale 1ns / 1ps
module fdc_datapath (
   input  logic                        clock,
   input  fdc_pkg::op_type             op,
   input  logic                        div_start,
   input  logic                        mod_start,
   input  logic [fdc_pkg::NumW-1:0]    req_number,
   output fdc_pkg::status_type         status,
   output logic [fdc_pkg::ResW-1:0]    product
);
   import fdc_pkg::*;

   logic [ExpW-1:0] mem_ff [0:MaxN];
   logic [NumW-1:0] n_ff, k_ff, rest_ff, cand_ff, idx_ff;
   logic [ExpW-1:0] rd_ff;
   logic [NumW-1:0] quo_ff, rem_ff;
   logic [3:0]      dcnt_ff;
   logic [ModW+ExpW:0] mrem_ff;
   logic [ModW+ExpW:0] mrem_in;
   logic [5:0]      mcnt_ff;
   logic [ModW-1:0] prod_ff;
   logic [NumW:0]   rem_sh;
   logic [NumW-1:0] wr_addr;
   logic [ExpW-1:0] wr_data;
   logic            wr_en;

   // restoring divider rest / cand, one quotient bit a cycle
   assign rem_sh = {rem_ff, quo_ff[NumW-1]};

   always_ff @(posedge clock) begin
      if (op == OP_IDLE) begin
         n_ff <= (req_number > MaxNVal) ? MaxNVal : req_number;
         idx_ff <= '0;
         prod_ff <= ModW'(1);
      end
      if (op == OP_CLEAR) idx_ff <= status.clear_last ? '0 : idx_ff + 1'b1;
      if (op == OP_LOADK) begin
         rest_ff <= k_ff;
         cand_ff <= NumW'(2);
      end
      if (div_start) begin
         quo_ff <= rest_ff;
         rem_ff <= '0;
         dcnt_ff <= 4'(NumW);
      end else if (dcnt_ff != 0) begin
         dcnt_ff <= dcnt_ff - 1'b1;
         if (rem_sh >= {1'b0, cand_ff}) begin
            rem_ff <= NumW'(rem_sh - {1'b0, cand_ff});
            quo_ff <= {quo_ff[NumW-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[NumW-1:0];
            quo_ff <= {quo_ff[NumW-2:0], 1'b0};
         end
      end
      if (op == OP_BUMP) rest_ff <= quo_ff;
      if (op == OP_NEXTI) cand_ff <= cand_ff + 1'b1;
      if (op == OP_NEXTK) k_ff <= k_ff + 1'b1;
      // k starts one below 2: the first NEXTK steps it to 2 or ends at once
      if (op == OP_CLEAR && status.clear_last) k_ff <= NumW'(1);
      if (op == OP_SCAN_RD || op == OP_BUMP || op == OP_LEFTOVER) begin
         rd_ff <= mem_ff[(op == OP_SCAN_RD) ? idx_ff :
                         (op == OP_BUMP) ? cand_ff : rest_ff];
      end
      if (op == OP_SCAN_NEXT) idx_ff <= idx_ff + 1'b1;
      if (op == OP_NEXTK && status.k_last) idx_ff <= NumW'(2);
      // mod reduction of prod*(e+1): shift-subtract over the product bits
      if (mod_start) begin
         mrem_ff <= '0;
         mcnt_ff <= 6'(ModW);
      end else if (mcnt_ff != 0) begin
         mcnt_ff <= mcnt_ff - 1'b1;
         mrem_ff <= mrem_in;
      end
      if (op == OP_MOD && mcnt_ff == 0 && !mod_start) prod_ff <= mrem_ff[ModW-1:0];
      if (wr_en) mem_ff[wr_addr] <= wr_data;
   end

   // Horner: r = (2r + bit*(e+1)) mod M, operands stay below 2^31
   always_comb begin
      logic [ModW+ExpW:0] t;
      t = {mrem_ff[ModW+ExpW-1:0], 1'b0};
      if (prod_ff[mcnt_ff[4:0] - 5'd1]) t = t + (ModW+ExpW+1)'(rd_ff) + 1'b1;
      if (t >= (ModW+ExpW+1)'(Modulus)) t = t - (ModW+ExpW+1)'(Modulus);
      if (t >= (ModW+ExpW+1)'(Modulus)) t = t - (ModW+ExpW+1)'(Modulus);
      mrem_in = t;
   end

   // bump ops write in the cycle after the read: pipelined via a delay register
   logic            bump_ff;
   logic [NumW-1:0] bump_addr_ff;
   always_ff @(posedge clock) begin
      bump_ff <= (op == OP_BUMP) || (op == OP_LEFTOVER && status.rest_gt1);
      bump_addr_ff <= (op == OP_BUMP) ? cand_ff : rest_ff;
   end

   always_comb begin
      wr_en = 1'b0;
      wr_addr = idx_ff;
      wr_data = '0;
      if (op == OP_CLEAR) wr_en = 1'b1;
      else if (bump_ff) begin
         wr_en = 1'b1;
         wr_addr = bump_addr_ff;
         wr_data = rd_ff + 1'b1;
      end
   end

   assign status.clear_last = (idx_ff == MaxNVal);
   assign status.k_last = (k_ff >= n_ff);
   assign status.div_done = (dcnt_ff == 0);
   assign status.divisible = (rem_ff == 0);
   assign status.cand_over = ({10'd0, cand_ff} * {10'd0, cand_ff}) > {10'd0, rest_ff};
   assign status.rest_gt1 = (rest_ff > NumW'(1));
   assign status.scan_last = (idx_ff == MaxNVal);
   assign status.exp_nonzero = (rd_ff != 0);
   assign status.mod_done = (mcnt_ff == 0);
   assign product = prod_ff;
endmodule

// File: hw/rtl/fdc_controller.sv
`timescale 1ns / 1ps
module fdc_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  fdc_pkg::status_type  status,
   output fdc_pkg::op_type      op,
   output logic                 div_start,
   output logic                 mod_start,
   output logic                 busy,
   output logic                 rsp_valid
);
   import fdc_pkg::*;

   op_type op_ff, op_in;
   logic   started_ff, started_in;
   logic   rsp_ff, rsp_in;

   always_comb begin
      op_in = op_ff;
      started_in = 1'b0;
      rsp_in = 1'b0;
      case (op_ff)
         OP_IDLE:     if (start) op_in = OP_CLEAR;
         OP_CLEAR:    if (status.clear_last) op_in = OP_NEXTK;
         OP_LOADK:    op_in = OP_DIV;
         OP_DIV: begin
            if (status.cand_over) op_in = OP_LEFTOVER;
            else if (!started_ff) started_in = 1'b1;
            else if (status.div_done) begin
               op_in = status.divisible ? OP_BUMP : OP_NEXTI;
            end else started_in = 1'b1;
         end
         OP_BUMP:     op_in = OP_DIV;
         OP_NEXTI:    op_in = OP_DIV;
         OP_LEFTOVER: op_in = OP_NEXTK;
         OP_NEXTK:    op_in = status.k_last ? OP_SCAN_RD : OP_LOADK;
         OP_SCAN_RD:  op_in = OP_SCAN_MUL;
         OP_SCAN_MUL: op_in = status.exp_nonzero ? OP_MOD : OP_SCAN_NEXT;
         OP_MOD: begin
            if (!started_ff) started_in = 1'b1;
            else if (status.mod_done) op_in = OP_SCAN_NEXT;
            else started_in = 1'b1;
         end
         OP_SCAN_NEXT: op_in = status.scan_last ? OP_DONE : OP_SCAN_RD;
         OP_DONE: begin
            op_in = OP_IDLE;
            rsp_in = 1'b1;
         end
         default:     op_in = OP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= OP_IDLE;
         started_ff <= 1'b0;
         rsp_ff <= 1'b0;
      end else begin
         op_ff <= op_in;
         started_ff <= started_in;
         rsp_ff <= rsp_in;
      end
   end

   assign op = op_ff;
   assign div_start = (op_ff == OP_DIV) && !started_ff && !status.cand_over;
   assign mod_start = (op_ff == OP_MOD) && !started_ff;
   assign busy = (op_ff != OP_IDLE);
   assign rsp_valid = rsp_ff;

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_ff |-> op_ff == OP_IDLE) else $error("response outside idle");
   a_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> op_ff == OP_CLEAR) else $error("start lost");
   a_done: assert property (@(posedge clock) disable iff (reset)
      op_ff == OP_DONE |=> rsp_ff) else $error("no response");
endmodule

// File: test/factorial_divisor_count_test.sv
`timescale 1ns / 1ps
// Self-checking bench for factorial_divisor_count.
// A directed table runs first: zero, one, a few small n with known counts,
// and the largest n. Then random transactions follow, mostly small n to keep
// the run short. Every result is checked against a typed-in count or a local divisor-count model.
module factorial_divisor_count_test;
   import fdc_pkg::*;

   localparam int unsigned CycleLimit = 10_000_000;
   localparam int unsigned DrainCycles = 2000;
   localparam int unsigned RandomCount = 100;

   typedef struct {
      logic [NumW-1:0] number;
      bit              known;     // expected value typed in below
      logic [ResW-1:0] count;
   } stim_row_type;

   typedef struct {
      logic [NumW-1:0] number;
      logic [ResW-1:0] count;
   } pending_count_type;

   logic            clock;
   logic            reset;
   logic            start;
   logic            busy;
   logic [NumW-1:0] req_number;
   logic            rsp_valid;
   logic [ResW-1:0] rsp_divisor_count;

   pending_count_type pending_counts[$];
   int unsigned     error_count;
   int unsigned     cycle_count;
   int unsigned     sent_count;
   int unsigned     checked_count;
   int unsigned     idle_pct;

   // directed rows; known counts only where obvious
   stim_row_type directed_rows[] = '{
      '{10'd0,    1'b1, 30'd1},     // small n: empty product
      '{10'd1,    1'b1, 30'd1},
      '{10'd2,    1'b1, 30'd2},
      '{10'd3,    1'b1, 30'd4},     // 6
      '{10'd4,    1'b1, 30'd8},     // 2^3 * 3
      '{10'd5,    1'b1, 30'd16},    // 2^3 * 3 * 5
      '{10'd6,    1'b0, 30'd0},
      '{10'd7,    1'b0, 30'd0},
      '{10'd8,    1'b0, 30'd0},
      '{10'd16,   1'b0, 30'd0},
      '{10'd31,   1'b0, 30'd0},
      '{10'd32,   1'b0, 30'd0},
      '{10'd63,   1'b0, 30'd0},
      '{10'd64,   1'b0, 30'd0},
      '{10'd100,  1'b0, 30'd0},
      '{10'd255,  1'b0, 30'd0},
      '{10'd1023, 1'b0, 30'd0},     // largest n, all bits set
      '{10'd0,    1'b1, 30'd1}      // back to the bottom after the largest
   };

   factorial_divisor_count dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_number        (req_number),
      .rsp_valid         (rsp_valid),
      .rsp_divisor_count (rsp_divisor_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // d(n!) mod 1000000007 by trial division of every k up to n
   function automatic logic [ResW-1:0] factorial_divisors(input logic [NumW-1:0] number);
      int unsigned       expo [0:MaxN];
      int unsigned       n;
      int unsigned       rest;
      int unsigned       cand;
      longint unsigned   product;
      for (int i = 0; i <= MaxN; i++) expo[i] = 0;
      n = (number > MaxN) ? MaxN : number;
      for (int unsigned k = 2; k <= n; k++) begin
         rest = k;
         for (cand = 2; cand * cand <= rest; cand++) begin
            while (rest % cand == 0) begin
               expo[cand]++;
               rest = rest / cand;
            end
         end
         if (rest > 1 && rest <= MaxN) expo[rest]++;
      end
      product = 1;
      for (int unsigned k = 2; k <= MaxN; k++) begin
         if (expo[k] != 0) product = (product * (expo[k] + 1)) % Modulus;
      end
      return ResW'(product);
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      $display("MISMATCH @%0t: %s", $realtime, what);
   endtask

   // one transaction: hold start until an edge sees busy low
   task automatic issue_number(input logic [NumW-1:0] number, input bit known,
                               input logic [ResW-1:0] known_count);
      pending_count_type entry;
      int unsigned    gap;
      gap = 0;
      if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, 8);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start      <= 1'b1;
      req_number <= number;
      do @(posedge clock); while (busy);
      entry.number = number;
      entry.count  = known ? known_count : factorial_divisors(number);
      pending_counts.push_back(entry);
      sent_count++;
   endtask

   // result side: strobe is taken at the edge ending its cycle
   always @(posedge clock) begin
      pending_count_type head;
      if (!reset && rsp_valid) begin
         if (pending_counts.size() == 0) begin
            report_mismatch($sformatf("unexpected count %0d", rsp_divisor_count));
         end else begin
            head = pending_counts.pop_front();
            checked_count++;
            if (rsp_divisor_count !== head.count)
               report_mismatch($sformatf("n=%0d count %0d, want %0d",
                                         head.number, rsp_divisor_count, head.count));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("factorial_divisor_count test failed");
         $finish;
      end
   end

   function automatic logic [NumW-1:0] random_number();
      // mostly small n; the trial-division time grows fast with n
      if ($urandom_range(49) == 0) return NumW'($urandom_range(64, 200));
      if ($urandom_range(19) == 0) return NumW'($urandom_range(0, 1));
      return NumW'($urandom_range(2, 48));
   endfunction

   initial begin
      error_count   = 0;
      cycle_count   = 0;
      sent_count    = 0;
      checked_count = 0;
      idle_pct      = 0;
      reset         = 1'b1;
      start         = 1'b0;
      req_number    = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, no idling
      foreach (directed_rows[i])
         issue_number(directed_rows[i].number, directed_rows[i].known,
                      directed_rows[i].count);

      // random phases: back-to-back, sender idle 55 %, sender idle 16 %
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 0 : (phase == 1) ? 55 : 16;
         for (int j = 0; j < RandomCount / 3 + 1; j++)
            issue_number(random_number(), 1'b0, '0);
         if (phase == 1) begin
            // hold off until every outstanding count has come back
            start <= 1'b0;
            while (pending_counts.size() != 0) @(posedge clock);
         end
      end

      start <= 1'b0;
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      while (pending_counts.size() != 0) begin
         pending_count_type left;
         left = pending_counts.pop_front();
         report_mismatch($sformatf("no count for n=%0d", left.number));
      end

      $display("Sent %0d numbers (directed 0..1023, random mostly small), checked %0d counts.",
               sent_count, checked_count);
      $display("Idle phases: none, 55 %% and 16 %% sender gaps; %0d mismatches.", error_count);
      if (error_count == 0) begin
         $display("factorial_divisor_count test passed");
      end else begin
         $display("factorial_divisor_count test failed");
      end
      $finish;
   end
endmodule
